>>> src/lkv_pkg.sv
package lkv_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CapW  = 5;

  // Request kinds
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_STORE  = 1'b1;

  // Capacity after reset and values returned on a lookup miss and on a store
  localparam logic [CapW-1:0]  CAP_RESET  = 5'd16;
  localparam logic [DataW-1:0] MISS_VALUE = 32'hFFFF_FFFF;
  localparam logic [DataW-1:0] STORE_READ = 32'h0000_0000;

  typedef struct packed {
    logic             operation;
    logic [DataW-1:0] key;
    logic [DataW-1:0] value;
  } lkv_req_t;

  typedef struct packed {
    logic             hit;
    logic [DataW-1:0] read_value;
    logic             evicted;
  } lkv_res_t;

endpackage

>>> src/lkv_table.sv
module lkv_table #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     upd_i,
  input  lkv_pkg::lkv_req_t        req_i,
  input  logic [lkv_pkg::CapW-1:0] cap_i,
  output lkv_pkg::lkv_res_t        res_o
);

  localparam int unsigned RankW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CntW  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CmpW  = (CntW > lkv_pkg::CapW) ? CntW : lkv_pkg::CapW;

  logic [MAX_ENTRIES-1:0]        valid_q, valid_d;
  logic [RankW-1:0]              rank_q [MAX_ENTRIES];
  logic [RankW-1:0]              rank_d [MAX_ENTRIES];
  logic [lkv_pkg::DataW-1:0]     key_q  [MAX_ENTRIES];
  logic [lkv_pkg::DataW-1:0]     value_q[MAX_ENTRIES];
  logic [CntW-1:0]               count_q, count_d;

  logic [MAX_ENTRIES-1:0]        match, victim, free, slot;
  logic                          hit;
  logic [lkv_pkg::DataW-1:0]     hit_value;
  logic [RankW-1:0]              hit_rank;
  logic [RankW-1:0]              last_rank;
  logic [CntW-1:0]               count_dec;
  logic [lkv_pkg::CapW-1:0]      cap_eff;
  logic                          full;
  logic                          is_store, store_miss, evict;

  // Compare every valid key with the request key at once
  always_comb begin
    hit_value = '0;
    hit_rank  = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      match[i] = valid_q[i] && (key_q[i] == req_i.key);
      if (match[i]) begin
        hit_value = hit_value | value_q[i];
        hit_rank  = hit_rank | rank_q[i];
      end
    end
    hit = |match;
  end

  // The least recent entry holds the rank fill minus one
  assign count_dec = count_q - CntW'(1);
  assign last_rank = count_dec[RankW-1:0];
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      victim[i] = valid_q[i] && (rank_q[i] == last_rank);
    end
  end

  // Clamp capacity to 1 .. MAX_ENTRIES and check the fill against it
  assign cap_eff = (cap_i == '0) ? lkv_pkg::CapW'(1) : cap_i;
  assign full    = (CmpW'(count_q) >= CmpW'(cap_eff))
                || (count_q == CntW'(MAX_ENTRIES));

  assign is_store   = (req_i.operation == lkv_pkg::OP_STORE);
  assign store_miss = is_store && !hit;
  assign evict      = store_miss && full;

  // Pick the lowest free entry, counting a victim as free
  assign free = ~valid_q | (evict ? victim : '0);
  assign slot = free & (~free + MAX_ENTRIES'(1));

  // Next valid bits, ranks and fill
  always_comb begin
    valid_d = valid_q;
    count_d = count_q;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      rank_d[i] = rank_q[i];
    end
    if (hit) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (match[i]) begin
          rank_d[i] = '0;
        end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
          rank_d[i] = rank_q[i] + RankW'(1);
        end
      end
    end else if (is_store) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (slot[i]) begin
          valid_d[i] = 1'b1;
          rank_d[i]  = '0;
        end else if (evict && victim[i]) begin
          valid_d[i] = 1'b0;
          rank_d[i]  = '0;
        end else if (valid_q[i]) begin
          rank_d[i] = rank_q[i] + RankW'(1);
        end
      end
      if (!evict) begin
        count_d = count_q + CntW'(1);
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else if (upd_i) begin
      valid_q <= valid_d;
      count_q <= count_d;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank_q[i] <= rank_d[i];
      end
    end
  end

  // Keys and values: overwrite on a store hit, fill the chosen slot on a store miss
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (upd_i && is_store) begin
        if (match[i]) begin
          value_q[i] <= req_i.value;
        end else if (store_miss && slot[i]) begin
          key_q[i]   <= req_i.key;
          value_q[i] <= req_i.value;
        end
      end
    end
  end

  // Result of this request
  always_comb begin
    res_o.hit     = hit;
    res_o.evicted = evict;
    if (is_store) begin
      res_o.read_value = lkv_pkg::STORE_READ;
    end else if (hit) begin
      res_o.read_value = hit_value;
    end else begin
      res_o.read_value = lkv_pkg::MISS_VALUE;
    end
  end

endmodule

>>> src/lru_key_value_store.sv
// Fully associative key-value store with least-recently-used replacement.
// Input channel (in_valid_i / in_ready_o) carries one request per beat:
// operation_i (0 lookup, 1 store), key_i and value_i. Output channel
// (out_valid_o / out_ready_i) returns one beat per request: hit_o,
// read_value_o (value on a lookup hit, -1 on a lookup miss, 0 on a store)
// and evicted_o. Results come back in request order.
// A request waits in the input register until the output register is free;
// all key compares, the victim pick and the entry update happen in the cycle
// it moves on, and the result is registered in the output register that
// drives out_valid_o. One request per cycle is sustained while out_ready_i
// stays high, since each entry update completes before the next request.
// When the receiver stalls, the result stays in the output register and one
// more request is held in the input register; then in_ready_o drops.
// cfg_we_i writes cfg_wdata_i into the capacity register (0 acts as 1,
// values above MAX_ENTRIES act as MAX_ENTRIES); write only while idle.
// Reset empties the store at once and sets the capacity to 16.
module lru_key_value_store #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [lkv_pkg::CapW-1:0]   cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       operation_i,
  input  logic signed [31:0]         key_i,
  input  logic signed [31:0]         value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       hit_o,
  output logic signed [31:0]         read_value_o,
  output logic                       evicted_o
);

  logic                       in_valid_q;
  lkv_pkg::lkv_req_t          req_q;
  logic                       out_valid_q;
  lkv_pkg::lkv_res_t          res_q, res_d;
  logic [lkv_pkg::CapW-1:0]   cap_q;
  logic                       adv;

  // Move the held request into the output register when it is free
  assign adv        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || adv;

  // Capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lkv_pkg::CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // Handshake state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q.operation <= operation_i;
      req_q.key       <= key_i;
      req_q.value     <= value_i;
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  lkv_table #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_table (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .upd_i (adv),
    .req_i (req_q),
    .cap_i (cap_q),
    .res_o (res_d)
  );

  assign out_valid_o  = out_valid_q;
  assign hit_o        = res_q.hit;
  assign read_value_o = res_q.read_value;
  assign evicted_o    = res_q.evicted;

endmodule
